/* src/keyed_slot_count_table_assert.svh */
// ---------------------------------------------------------------------------
// keyed_slot_count_table assertion macros
// Concurrent assertion wrappers on clk_i, with and without reset qualify.
// ---------------------------------------------------------------------------
`ifndef KEYED_SLOT_COUNT_TABLE_ASSERT_SVH
`define KEYED_SLOT_COUNT_TABLE_ASSERT_SVH

// Check prop at every clk_i edge outside reset.
`define KSCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check prop at every clk_i edge, reset included.
`define KSCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* src/ksct_pkg.sv */
// ---------------------------------------------------------------------------
// ksct_pkg
// Shared types and constants of the keyed slot count table.
// ---------------------------------------------------------------------------
package ksct_pkg;

  localparam int unsigned SLOTS_DEF    = 16;
  localparam int unsigned KEY_BITS_DEF = 16;

  localparam int unsigned CAP_W      = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] item_key;
    logic [15:0] amount;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot_index;
    logic [31:0] new_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch request, read slot 0
    logic advance;    // step to next slot
    logic commit;     // update current slot, report ok
    logic fail_idle;  // report failure of the incoming word (no slots in use)
    logic fail_scan;  // report failure of the latched word
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;        // current slot satisfies the request
    logic last;       // current slot is the last one in use
    logic n_zero;     // no slots in use
  } dp_status_t;

endpackage

/* src/keyed_slot_count_table.sv */
// Scan: k slots are checked per word, k = 1 .. min(capacity, SLOTS), one slot per cycle
// through the single registered read port of the slot memory; a new word waits out the
// scan, and busy drops as the registered result strobe shows. With no slots in use the
// word fails at once and its strobe shows in the cycle after the accept.
// Reset: capacity 16, every slot empty at once through flip-flop occupancy flags.
// ---------------------------------------------------------------------------
// keyed_slot_count_table
// Table of keyed counters with add and remove requests and a capacity register.
// ---------------------------------------------------------------------------
module keyed_slot_count_table #(
  parameter int unsigned SLOTS    = ksct_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS = ksct_pkg::KEY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  ksct_pkg::req_t                 req_i,
  // result channel
  output logic                           result_valid_o,
  output ksct_pkg::rsp_t                 rsp_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ksct_pkg::PADDR_W-1:0]   paddr,
  input  logic [ksct_pkg::PDATA_W-1:0]   pwdata,
  output logic [ksct_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import ksct_pkg::*;

  ctrl_cmd_t        cmd;
  dp_status_t       st;
  logic             cfg_we;
  logic [CAP_W-1:0] cap;

  // Register write completes in the access phase; only the capacity word
  // exists, writes to any other word are dropped.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);

  // Read back the capacity; other words read as zero.
  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap) : '0;

  // Sequencer: accept, step slot by slot, stop on the first qualifying or last used slot.
  ksct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .st_i    (st),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Slot storage, compare and update logic, and the result register.
  ksct_dp #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .st_o           (st),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[CAP_W-1:0]),
    .cap_o          (cap),
    .rsp_o          (rsp_o),
    .result_valid_o (result_valid_o)
  );

endmodule

/* src/ksct_ctrl.sv */
// ---------------------------------------------------------------------------
// ksct_ctrl
// Scan sequencer: accept a word, step through slots, end on hit or last slot.
// ---------------------------------------------------------------------------
module ksct_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  ksct_pkg::dp_status_t   st_i,
  output ksct_pkg::ctrl_cmd_t    cmd_o,
  output logic                   busy_o
);
  import ksct_pkg::*;
  `include "keyed_slot_count_table_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (st_i.n_zero) begin
            cmd_o.fail_idle = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        priority if (st_i.hit) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end else if (st_i.last) begin
          cmd_o.fail_scan = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  `KSCT_ASSERT_ALWAYS(a_one_action,
    $onehot0({cmd_o.load, cmd_o.advance, cmd_o.commit, cmd_o.fail_idle, cmd_o.fail_scan}),
    "more than one datapath command at once")
  `KSCT_ASSERT(a_no_step_past_end, cmd_o.advance |-> !st_i.last,
    "scan stepped beyond the last slot in use")
  `KSCT_ASSERT(a_scan_ends, (state_q == S_SCAN && (st_i.hit || st_i.last)) |=> !busy_o,
    "scan did not finish on hit or last slot")

endmodule

/* src/ksct_dp.sv */
// ---------------------------------------------------------------------------
// ksct_dp
// Slot storage, capacity register, per-slot compare and update, result word.
// ---------------------------------------------------------------------------
module ksct_dp #(
  parameter int unsigned SLOTS    = ksct_pkg::SLOTS_DEF,
  parameter int unsigned KEY_BITS = ksct_pkg::KEY_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ksct_pkg::req_t               req_i,
  input  ksct_pkg::ctrl_cmd_t          cmd_i,
  output ksct_pkg::dp_status_t         st_o,
  input  logic                         cfg_we_i,
  input  logic [ksct_pkg::CAP_W-1:0]   cfg_wdata_i,
  output logic [ksct_pkg::CAP_W-1:0]   cap_o,
  output ksct_pkg::rsp_t               rsp_o,
  output logic                         result_valid_o
);
  import ksct_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned N_W   = $clog2(SLOTS + 1);
  localparam int unsigned CMP_W = (N_W > CAP_W) ? N_W : CAP_W;

  // capacity register and slots in use
  logic [CAP_W-1:0] cap_q;
  logic [N_W-1:0]   n_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign n_use = (CMP_W'(cap_q) > CMP_W'(SLOTS)) ? N_W'(SLOTS) : N_W'(cap_q);
  assign cap_o = cap_q;

  // latched request and scan index
  cmd_e                cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [15:0]         amt_q;
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    rd_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= req_i.cmd;
      key_q <= KEY_BITS'(req_i.item_key);
      amt_q <= req_i.amount;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.advance) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_comb begin
    priority if (cmd_i.load) begin
      rd_addr = '0;
    end else if (cmd_i.advance) begin
      rd_addr = idx_q + 1'b1;
    end else begin
      rd_addr = idx_q;
    end
  end

  // key and count memory; contents of an empty slot are never looked at
  logic [KEY_BITS-1:0] key_mem_q [SLOTS];
  logic [31:0]         cnt_mem_q [SLOTS];
  logic [KEY_BITS-1:0] rd_key_q;
  logic [31:0]         rd_cnt_q;
  logic [31:0]         upd_cnt;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      key_mem_q[idx_q] <= key_q;
      cnt_mem_q[idx_q] <= upd_cnt;
    end
    rd_key_q <= key_mem_q[rd_addr];
    rd_cnt_q <= cnt_mem_q[rd_addr];
  end

  // occupancy flags
  logic [SLOTS-1:0] used_q;
  logic             cur_used;

  assign cur_used = used_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cfg_we_i) begin
      // drop every slot at or above the new capacity
      for (int i = 0; i < SLOTS; i++) begin
        if (CMP_W'(i) >= CMP_W'(cfg_wdata_i)) begin
          used_q[i] <= 1'b0;
        end
      end
    end else if (cmd_i.commit) begin
      used_q[idx_q] <= (upd_cnt != '0) || (cmd_q == CMD_ADD);
    end
  end

  // compare and update of the current slot
  logic        key_eq;
  logic [32:0] sum;
  logic [31:0] sat_sum;
  logic [31:0] diff;
  logic        enough;
  logic        hit;

  assign key_eq  = (rd_key_q == key_q);
  assign sum     = {1'b0, rd_cnt_q} + 33'(amt_q);
  assign sat_sum = sum[32] ? '1 : sum[31:0];
  assign diff    = rd_cnt_q - 32'(amt_q);
  assign enough  = (rd_cnt_q >= 32'(amt_q));

  always_comb begin
    unique case (cmd_q)
      CMD_ADD: begin
        hit     = !cur_used || key_eq;
        upd_cnt = cur_used ? sat_sum : 32'(amt_q);
      end
      CMD_REMOVE: begin
        hit     = cur_used && key_eq && enough;
        upd_cnt = diff;
      end
      default: begin
        hit     = 1'b0;
        upd_cnt = '0;
      end
    endcase
  end

  assign st_o.hit    = hit;
  assign st_o.last   = (N_W'(idx_q) + 1'b1) >= n_use;
  assign st_o.n_zero = (n_use == '0);

  // result word, shown for one cycle
  rsp_t rsp_q;
  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.commit || cmd_i.fail_idle || cmd_i.fail_scan;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.commit) begin
      rsp_q.status     <= ST_OK;
      rsp_q.slot_index <= 4'(idx_q);
      rsp_q.new_count  <= upd_cnt;
    end else if (cmd_i.fail_idle) begin
      rsp_q.status     <= (req_i.cmd == CMD_REMOVE) ? ST_NOT_FOUND : ST_FULL;
      rsp_q.slot_index <= '0;
      rsp_q.new_count  <= '0;
    end else if (cmd_i.fail_scan) begin
      rsp_q.status     <= (cmd_q == CMD_REMOVE) ? ST_NOT_FOUND : ST_FULL;
      rsp_q.slot_index <= '0;
      rsp_q.new_count  <= '0;
    end
  end

  assign rsp_o          = rsp_q;
  assign result_valid_o = valid_q;

endmodule

/* tb/keyed_slot_count_table_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// keyed_slot_count_table testbench
// Drives add and remove words through the command port and changes the
// capacity over the APB port. A scoreboard class keeps its own copy of the
// slot table, works out the report of every accepted word, and checks each
// strobed report against the oldest one still owed.
// ---------------------------------------------------------------------------

class count_table_board;
  bit                   slot_used  [ksct_pkg::SLOTS_DEF];
  logic [15:0]          slot_key   [ksct_pkg::SLOTS_DEF];
  logic [31:0]          slot_count [ksct_pkg::SLOTS_DEF];
  int unsigned          live_slots;
  ksct_pkg::rsp_t       pending_reports[$];
  int unsigned          mismatches;
  int unsigned          n_ok, n_full, n_not_found, n_emptied, n_saturated;

  function new();
    live_slots  = ksct_pkg::SLOTS_DEF;
    mismatches  = 0;
    n_ok        = 0;
    n_full      = 0;
    n_not_found = 0;
    n_emptied   = 0;
    n_saturated = 0;
    for (int unsigned i = 0; i < ksct_pkg::SLOTS_DEF; i++) clear_slot(i);
  endfunction

  function void clear_slot(int unsigned i);
    slot_used[i]  = 1'b0;
    slot_key[i]   = '0;
    slot_count[i] = '0;
  endfunction

  // Shrinking drops every slot at or above the new capacity.
  function void track_capacity(logic [4:0] cap);
    live_slots = (cap < ksct_pkg::SLOTS_DEF) ? cap : ksct_pkg::SLOTS_DEF;
    for (int unsigned i = live_slots; i < ksct_pkg::SLOTS_DEF; i++) clear_slot(i);
  endfunction

  function logic [31:0] count_of(logic [15:0] key);
    logic [31:0] found;
    found = '0;
    for (int i = live_slots - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == key) found = slot_count[i];
    end
    return found;
  endfunction

  function void book_request(ksct_pkg::req_t w);
    ksct_pkg::rsp_t r;
    logic [32:0]    sum;
    bit             done;
    int unsigned    i;
    r.status     = (w.cmd == ksct_pkg::CMD_ADD) ? ksct_pkg::ST_FULL : ksct_pkg::ST_NOT_FOUND;
    r.slot_index = '0;
    r.new_count  = '0;
    done = 1'b0;
    for (i = 0; i < live_slots && !done; i++) begin
      if (w.cmd == ksct_pkg::CMD_ADD) begin
        if (!slot_used[i]) begin
          slot_used[i]  = 1'b1;
          slot_key[i]   = w.item_key;
          slot_count[i] = {16'h0000, w.amount};
          done = 1'b1;
        end else if (slot_key[i] == w.item_key) begin
          sum = {1'b0, slot_count[i]} + {17'h0, w.amount};
          if (sum[32]) n_saturated++;
          slot_count[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          done = 1'b1;
        end
      end else if (slot_used[i] && slot_key[i] == w.item_key
                   && slot_count[i] >= {16'h0000, w.amount}) begin
        slot_count[i] = slot_count[i] - {16'h0000, w.amount};
        if (slot_count[i] == 0) begin
          clear_slot(i);
          n_emptied++;
        end
        done = 1'b1;
      end
      if (done) begin
        r.status     = ksct_pkg::ST_OK;
        r.slot_index = i[3:0];
        r.new_count  = slot_count[i];
      end
    end
    case (r.status)
      ksct_pkg::ST_OK:   n_ok++;
      ksct_pkg::ST_FULL: n_full++;
      default:           n_not_found++;
    endcase
    pending_reports.push_back(r);
  endfunction

  function void check_report(ksct_pkg::rsp_t got);
    ksct_pkg::rsp_t want;
    if (pending_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected report: status %0d slot %0d count %h",
                 got.status, got.slot_index, got.new_count);
    end else begin
      want = pending_reports.pop_front();
      if (got.status !== want.status || got.slot_index !== want.slot_index
          || got.new_count !== want.new_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected st %0d slot %0d cnt %h, got st %0d slot %0d cnt %h",
                   want.status, want.slot_index, want.new_count,
                   got.status, got.slot_index, got.new_count);
      end
    end
  endfunction
endclass

module keyed_slot_count_table_tb;
  import ksct_pkg::*;

  localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  localparam int unsigned        PHASES        = 10;
  localparam int unsigned        PILE_ADDS     = 20;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  req_t                req_i   = '0;
  logic                result_valid_o;
  rsp_t                rsp_o;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  count_table_board    board;
  bit                  idle_on;
  int unsigned         cap_writes;

  // Keys that recur often, so adds and removes keep landing on live slots.
  logic [15:0]         key_pool [6] = '{16'h0000, 16'h0001, 16'hFFFF,
                                        16'h8000, 16'h1234, 16'h00FF};
  logic [4:0]          phase_cap [PHASES] = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1,
                                               5'd8, 5'd17, 5'd5, 5'd0, 5'd16};

  keyed_slot_count_table i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 10 ns clock: high half, low half.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Report monitor: the strobe lasts one cycle and cannot be held off, so
  // take the report at the rising edge that closes that cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) board.check_report(rsp_o);
  end

  // Offer one word, starting at a falling edge. Optionally drop start for a
  // random gap first, then hold the word until an edge sees busy low. Return
  // at the falling edge after the accept so the caller can chain the next
  // word without touching start twice in one step.
  task automatic drive_word(input cmd_e c, input logic [15:0] k, input logic [15:0] a);
    req_t        w;
    int unsigned gap;
    w.cmd      = c;
    w.item_key = k;
    w.amount   = a;
    if (idle_on && $urandom_range(99) < 32) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.book_request(w);
    @(negedge clk_i);
  endtask

  // Drop start and hold until every owed report has come back, then let
  // the block settle fully idle.
  task automatic settle_table();
    start <= 1'b0;
    while (board.pending_reports.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // APB write of the capacity register: setup cycle, then access cycle
  // until pready. Upper data bits carry noise the register must ignore.
  task automatic write_capacity(input logic [4:0] cap);
    logic [31:0] noise;
    noise = $urandom;
    settle_table();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= {noise[31:5], cap};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.track_capacity(cap);
    cap_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic        is_add;
    logic [15:0] key;
    logic [15:0] amt;
    int unsigned roll;
    int unsigned n_items;

    board      = new();
    cap_writes = 0;
    idle_on    = 1'b1;

    // Hold reset, then release it on a falling edge.
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: capacity at its reset value of 16.
    drive_word(CMD_ADD,    16'h0000, 16'h0000);  // add of zero still claims the slot
    drive_word(CMD_ADD,    16'hFFFF, 16'hFFFF);
    drive_word(CMD_ADD,    16'hFFFF, 16'hFFFF);  // match: count past 16 bits
    drive_word(CMD_REMOVE, 16'hFFFF, 16'hFFFF);
    drive_word(CMD_REMOVE, 16'hFFFF, 16'hFFFF);  // reaches zero, slot emptied
    drive_word(CMD_REMOVE, 16'h0000, 16'h0000);  // zero count, zero amount: emptied
    drive_word(CMD_REMOVE, 16'h0000, 16'h0000);  // empty slots never match
    drive_word(CMD_ADD,    16'h1234, 16'h0005);
    drive_word(CMD_ADD,    16'h5678, 16'h0007);
    drive_word(CMD_REMOVE, 16'h1234, 16'h0005);
    drive_word(CMD_ADD,    16'h5678, 16'h0003);  // reuses the hole: key now twice
    drive_word(CMD_REMOVE, 16'h5678, 16'h0006);  // first copy too small, skip it
    drive_word(CMD_REMOVE, 16'h5678, 16'h0002);

    // Shrink to two slots: both hold the key, so a new key finds no room.
    write_capacity(5'd2);
    drive_word(CMD_ADD,    16'h0001, 16'h0001);
    drive_word(CMD_REMOVE, 16'h5678, 16'hFFFF);

    // Zero capacity: everything cleared, every word fails.
    write_capacity(5'd0);
    drive_word(CMD_ADD,    16'h8000, 16'h0001);
    drive_word(CMD_REMOVE, 16'h5678, 16'h0001);

    // Capacity beyond the table: all slots live, none cleared.
    write_capacity(5'd31);
    drive_word(CMD_ADD,    16'h8000, 16'h0001);
    drive_word(CMD_REMOVE, 16'h8000, 16'h0002);

    // Pile-up: one live slot, stack the largest amount on one key back to
    // back, then back off once.
    write_capacity(5'd1);
    idle_on = 1'b0;
    for (int unsigned n = 0; n < PILE_ADDS; n++) drive_word(CMD_ADD, 16'h8000, 16'hFFFF);
    drive_word(CMD_REMOVE, 16'h8000, 16'hFFFF);
    idle_on = 1'b1;

    // Random phases across a spread of capacities. Phases 3 and 4 run with
    // the sender never idling.
    phase_cap[8] = 5'($urandom_range(0, 31));
    for (int unsigned p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      idle_on = (p != 3 && p != 4);
      n_items = (phase_cap[p] == 0) ? 15 : 80;
      for (int unsigned n = 0; n < n_items; n++) begin
        // Mid-phase, stop feeding until the table has answered everything.
        if (p == 5 && n == 40) settle_table();
        is_add = ($urandom_range(99) < 55);
        key    = ($urandom_range(99) < 80) ? key_pool[$urandom_range(5)]
                                           : 16'($urandom_range(0, 65535));
        roll   = $urandom_range(99);
        if (is_add) begin
          if (roll < 10)      amt = 16'h0000;
          else if (roll < 80) amt = 16'($urandom_range(1, 20));
          else                amt = 16'($urandom_range(0, 65535));
        end else begin
          // Often take exactly what the first copy holds, to empty slots.
          if (roll < 25)      amt = board.count_of(key) > 32'hFFFF
                                    ? 16'hFFFF : 16'(board.count_of(key));
          else if (roll < 85) amt = 16'($urandom_range(0, 20));
          else                amt = 16'($urandom_range(0, 65535));
        end
        drive_word(is_add ? CMD_ADD : CMD_REMOVE, key, amt);
      end
    end

    // Drain, then wait longer than a full scan would take, so that any stray
    // report shows.
    settle_table();
    repeat (SLOTS_DEF + 4) @(posedge clk_i);

    $display("run covered %0d words: %0d ok, %0d full, %0d not found",
             board.n_ok + board.n_full + board.n_not_found,
             board.n_ok, board.n_full, board.n_not_found);
    $display("%0d slots emptied, %0d saturated adds, %0d capacity writes, %0d mismatches",
             board.n_emptied, board.n_saturated, cap_writes,
             board.mismatches + board.pending_reports.size());
    if (board.mismatches == 0 && board.pending_reports.size() == 0) begin
      $display("keyed_slot_count_table test passed");
    end else begin
      $display("keyed_slot_count_table test failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("keyed_slot_count_table test failed");
    $finish;
  end

endmodule
